>>> design/rgbw_pwm_color_sequencer_macros.svh
// assertion macros used by the checker file of the rgbw color sequencer
// depends on: nothing; expects clk and rst_n in the scope of use
`ifndef RGBW_PWM_COLOR_SEQUENCER_MACROS_SVH
`define RGBW_PWM_COLOR_SEQUENCER_MACROS_SVH

// property checked only while out of reset
`define RGBWSEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that also looks at the reset itself
`define RGBWSEQ_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/rgbwseq_pkg.sv
// types, constants and table lookups of the rgbw color sequencer
// depends on: nothing
`timescale 1ns / 1ps

package rgbwseq_pkg;

    // pwm period length and top dim step
    localparam int PWM_STEPS = 8;
    localparam int DIM_TOP   = 5;
    localparam int ROM_SIZE  = 50;

    localparam logic [3:0] PWM_STEPS_L = 4'(PWM_STEPS);
    localparam logic [2:0] DIM_TOP_L   = 3'(DIM_TOP);

    // item command
    typedef enum logic {
        CMD_TICK   = 1'b0,
        CMD_BUTTON = 1'b1
    } cmd_t;

    // jumper codes
    localparam logic [3:0] CODE_NEXT        = 4'd0;
    localparam logic [3:0] CODE_STATIC_LAST = 4'd9;
    localparam logic [3:0] CODE_BLINK_A     = 4'd10;
    localparam logic [3:0] CODE_BLINK_B     = 4'd11;
    localparam logic [3:0] CODE_WARM        = 4'd12;
    localparam logic [3:0] CODE_COOL        = 4'd13;
    localparam logic [3:0] CODE_FIRE        = 4'd14;
    localparam logic [3:0] CODE_RAINBOW     = 4'd15;

    // color wheels
    typedef enum logic [2:0] {
        W_BLINK_A = 3'd0,
        W_BLINK_B = 3'd1,
        W_WARM    = 3'd2,
        W_COOL    = 3'd3,
        W_FIRE    = 3'd4,
        W_RAINBOW = 3'd5
    } wheel_id_t;

    localparam logic [5:0] SHORT_WHEEL_LEN   = 6'd2;
    localparam logic [5:0] LONG_WHEEL_LEN    = 6'd24;
    localparam logic [5:0] RAINBOW_WHEEL_LEN = 6'd48;
    localparam logic [15:0] SELECT_PAUSE     = 16'd16;

    // channel levels, index 0..3 = red, green, blue, white
    typedef logic [0:3][3:0] rgbw_t;

    typedef struct packed {
        logic       cmd;
        logic       dim_button;
        logic       select_button;
        logic [3:0] jumpers;
    } item_t;

    typedef struct packed {
        logic       red_on;
        logic       green_on;
        logic       blue_on;
        logic       white_on;
        logic [2:0] dim_level;
    } result_t;

    localparam logic [7:0]  DIM_TABLE [6]   = '{8'd0, 8'd4, 8'd16, 8'd32, 8'd64, 8'd128};
    localparam logic [15:0] PAUSE_TABLE [6] =
        '{16'd32768, 16'd32768, 16'd4096, 16'd8192, 16'd8192, 16'd8192};
    localparam logic [5:0]  STATIC_PICK [9] =
        '{6'd0, 6'd3, 6'd7, 6'd14, 6'd16, 6'd20, 6'd32, 6'd36, 6'd45};
    localparam logic [5:0]  WHEEL_A [2] = '{6'd0, 6'd16};
    localparam logic [5:0]  WHEEL_B [2] = '{6'd36, 6'd4};
    localparam logic [5:0]  WHEEL_C [24] = '{
        6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32,
        6'd32, 6'd31, 6'd30, 6'd29, 6'd28, 6'd27, 6'd26, 6'd25, 6'd24, 6'd23, 6'd22, 6'd21};
    localparam logic [5:0]  WHEEL_D [24] = '{
        6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd23, 6'd26, 6'd29, 6'd32, 6'd35, 6'd36,
        6'd37, 6'd36, 6'd33, 6'd30, 6'd27, 6'd24, 6'd21, 6'd19, 6'd18, 6'd17, 6'd15, 6'd14};
    localparam logic [5:0]  WHEEL_E [24] = '{
        6'd0, 6'd0, 6'd1, 6'd2, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9,
        6'd10, 6'd10, 6'd9, 6'd8, 6'd7, 6'd6, 6'd5, 6'd4, 6'd3, 6'd2, 6'd1, 6'd1};

    // one nibble per channel: red, green, blue, white
    localparam rgbw_t COLOR_ROM [50] = '{
        16'h8000, 16'h8100, 16'h8200, 16'h8300, 16'h8401, 16'h8501, 16'h8602, 16'h8702,
        16'h8803, 16'h7802, 16'h6801, 16'h5800, 16'h4800, 16'h3800, 16'h2800, 16'h1800,
        16'h0800, 16'h0810, 16'h0820, 16'h0830, 16'h0840, 16'h0850, 16'h0860, 16'h0870,
        16'h0880, 16'h0780, 16'h0680, 16'h0580, 16'h0480, 16'h0380, 16'h0280, 16'h0180,
        16'h0080, 16'h1080, 16'h2080, 16'h3080, 16'h4080, 16'h5080, 16'h6080, 16'h7080,
        16'h8080, 16'h8070, 16'h8060, 16'h8050, 16'h8040, 16'h8030, 16'h8020, 16'h8010,
        16'h0008, 16'h8888};

    // color number at a wheel position, red when out of range
    function automatic logic [5:0] wheel_entry(wheel_id_t id, logic [5:0] pos);
        logic [5:0] color;
        color = 6'd0;
        unique case (id)
            W_BLINK_A: if (pos < 6'd2) color = WHEEL_A[pos[0]];
            W_BLINK_B: if (pos < 6'd2) color = WHEEL_B[pos[0]];
            W_WARM:    if (pos < 6'd24) color = WHEEL_C[pos[4:0]];
            W_COOL:    if (pos < 6'd24) color = WHEEL_D[pos[4:0]];
            W_FIRE:    if (pos < 6'd24) color = WHEEL_E[pos[4:0]];
            W_RAINBOW: if (pos < 6'(ROM_SIZE)) color = pos;
            default:   color = 6'd0;
        endcase
        return color;
    endfunction

    // channel levels of a color, red when out of range
    function automatic rgbw_t color_levels(logic [5:0] color);
        rgbw_t lv;
        lv = COLOR_ROM[0];
        if (color < 6'(ROM_SIZE))
            lv = COLOR_ROM[color];
        return lv;
    endfunction

    // blanking length for a dim step, clamped to the last entry
    function automatic logic [7:0] dim_blank(logic [2:0] idx);
        return DIM_TABLE[(idx < 3'd6) ? idx : 3'd5];
    endfunction

    // pause reload for a pattern, clamped to the last entry
    function automatic logic [15:0] pause_reload(logic [2:0] pat);
        return PAUSE_TABLE[(pat < 3'd6) ? pat : 3'd5];
    endfunction

endpackage

>>> design/rgbwseq_item_if.sv
// input channel of the rgbw color sequencer: valid/ready plus one item
// depends on: nothing
`timescale 1ns / 1ps

interface rgbwseq_item_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic       dim_button;
    logic       select_button;
    logic [3:0] jumpers;

    modport source (output valid, cmd, dim_button, select_button, jumpers, input ready);
    modport sink   (input valid, cmd, dim_button, select_button, jumpers, output ready);
endinterface

>>> design/rgbwseq_result_if.sv
// result channel of the rgbw color sequencer: valid/ready plus led drive and dim level
// depends on: nothing
`timescale 1ns / 1ps

interface rgbwseq_result_if;
    logic       valid;
    logic       ready;
    logic       red_on;
    logic       green_on;
    logic       blue_on;
    logic       white_on;
    logic [2:0] dim_level;

    modport source (output valid, red_on, green_on, blue_on, white_on, dim_level,
                    input ready);
    modport sink   (input valid, red_on, green_on, blue_on, white_on, dim_level,
                    output ready);
endinterface

>>> design/rgbw_pwm_color_sequencer.sv
// top level of the rgbw pwm color sequencer: input register, core, result register
// depends on: rgbwseq_pkg, rgbwseq_item_if, rgbwseq_result_if, rgbwseq_core
//
//   channel   dir   payload                                        per transfer
//   items     in    cmd, dim_button, select_button, jumpers         one tick or button sample
//   results   out   red_on, green_on, blue_on, white_on, dim_level  one per item
//
// one item per cycle sustained while results are taken; the result is valid once the item
// has passed the input register, then the core update into the result register
// the core state update is a single combinational pass per item
// reset clears the valid flags and the core state to their power-up values; no clearing pass
// a stalled result holds; an item is still taken while the input register is empty
`timescale 1ns / 1ps

module rgbw_pwm_color_sequencer
    import rgbwseq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    rgbwseq_item_if.sink      items,
    rgbwseq_result_if.source  results
);

    logic    hold_valid_reg;
    logic    hold_valid_next;
    item_t   item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t core_result;
    logic    advance;
    logic    in_xfer;

    // handshake
    assign advance         = hold_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready     = !hold_valid_reg || advance;
    assign in_xfer         = items.valid && items.ready;
    assign hold_valid_next = in_xfer || (hold_valid_reg && !advance);
    assign out_valid_next  = advance || (out_valid_reg && !results.ready);

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            item_reg <= '{
                cmd:           items.cmd,
                dim_button:    items.dim_button,
                select_button: items.select_button,
                jumpers:       items.jumpers
            };
        if (advance)
            result_reg <= core_result;
    end

    // state and update
    rgbwseq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (core_result)
    );

    // result channel
    assign results.valid     = out_valid_reg;
    assign results.red_on    = result_reg.red_on;
    assign results.green_on  = result_reg.green_on;
    assign results.blue_on   = result_reg.blue_on;
    assign results.white_on  = result_reg.white_on;
    assign results.dim_level = result_reg.dim_level;

endmodule

>>> design/rgbwseq_core.sv
// sequencer state and its combinational update for one pwm tick or button sample
// depends on: rgbwseq_pkg
`timescale 1ns / 1ps

module rgbwseq_core
    import rgbwseq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    typedef struct packed {
        logic [3:0]  pwm_phase;
        logic [7:0]  blank_left;
        logic [7:0]  blank_length;
        logic [2:0]  dim_index;
        logic        dim_going_down;
        logic [15:0] pause_left;
        logic        static_mode;
        wheel_id_t   wheel_id;
        logic [5:0]  wheel_length;
        logic [5:0]  wheel_pos;
        logic [7:0]  selection;
        logic [2:0]  pattern_index;
        rgbw_t       levels;
        logic [1:0]  held;
        logic [0:3]  led;
    } state_t;

    localparam state_t STATE_RESET = '{
        pwm_phase:      PWM_STEPS_L,
        blank_left:     8'd0,
        blank_length:   8'd32,
        dim_index:      3'd3,
        dim_going_down: 1'b0,
        pause_left:     16'd1,
        static_mode:    1'b1,
        wheel_id:       W_RAINBOW,
        wheel_length:   6'd0,
        wheel_pos:      6'd0,
        selection:      8'd255,
        pattern_index:  3'd0,
        levels:         16'h0008,
        held:           2'b00,
        led:            4'b0000
    };

    state_t state_reg;
    state_t state_next;

    // next state for the item at hand
    always_comb
    begin
        state_t     s;
        logic       blanking;
        logic [3:0] dim_up;
        s        = state_reg;
        blanking = 1'b1;
        dim_up   = 4'd0;

        if (item.cmd == CMD_TICK)
        begin
            // pwm steps of the period
            if (s.pwm_phase != 4'd0)
            begin
                s.pwm_phase = s.pwm_phase - 4'd1;
                if (!s.static_mode)
                    s.pause_left = s.pause_left - 16'd1;
                if (s.pwm_phase != 4'd0)
                begin
                    for (int c = 0; c < 4; c++)
                        if (s.pwm_phase <= s.levels[c])
                            s.led[c] = 1'b1;
                    blanking = 1'b0;
                end
                else if (s.blank_left == 8'd0)
                begin
                    // period end with no blanking: full channels stay lit
                    for (int c = 0; c < 4; c++)
                        if (s.levels[c] != PWM_STEPS_L)
                            s.led[c] = 1'b0;
                    if (!s.static_mode && s.pause_left != 16'd0)
                        s.pause_left = s.pause_left - 16'd1;
                    s.blank_left = s.blank_length;
                    s.pwm_phase  = PWM_STEPS_L;
                    blanking     = 1'b0;
                end
            end

            // blanking ticks
            if (blanking)
            begin
                if (s.blank_left != 8'd0)
                begin
                    s.led        = 4'b0000;
                    s.blank_left = s.blank_left - 8'd1;
                    if (!s.static_mode && s.pause_left != 16'd0)
                        s.pause_left = s.pause_left - 16'd1;
                end
                if (s.blank_left == 8'd0)
                begin
                    s.blank_left = s.blank_length;
                    s.pwm_phase  = PWM_STEPS_L;
                end
            end

            // wheel step when the pause runs out
            if (s.pause_left == 16'd0)
            begin
                s.wheel_pos = s.wheel_pos + 6'd1;
                if (s.wheel_pos >= s.wheel_length)
                    s.wheel_pos = 6'd0;
                s.levels     = color_levels(wheel_entry(s.wheel_id, s.wheel_pos));
                s.pause_left = pause_reload(s.pattern_index);
            end
        end
        else
        begin
            // dim button edge: ping-pong over the dim steps
            if (s.held[0])
            begin
                if (!item.dim_button)
                    s.held[0] = 1'b0;
            end
            else if (item.dim_button)
            begin
                s.held[0] = 1'b1;
                if (s.dim_going_down)
                begin
                    if (s.dim_index != 3'd0)
                        s.dim_index = s.dim_index - 3'd1;
                    if (s.dim_index == 3'd0)
                        s.dim_going_down = 1'b0;
                end
                else
                begin
                    dim_up = {1'b0, s.dim_index} + 4'd1;
                    if (dim_up > {1'b0, DIM_TOP_L})
                        dim_up = {1'b0, DIM_TOP_L};
                    s.dim_index = dim_up[2:0];
                    if (s.dim_index == DIM_TOP_L)
                        s.dim_going_down = 1'b1;
                end
                s.blank_length = dim_blank(s.dim_index);
            end

            // select button edge: load the jumper code, or step the fixed color for code next
            if (s.held[1])
            begin
                if (!item.select_button)
                    s.held[1] = 1'b0;
            end
            else if (item.select_button)
            begin
                s.held[1]    = 1'b1;
                s.pause_left = SELECT_PAUSE;
                s.wheel_id   = W_RAINBOW;
                if (item.jumpers != CODE_NEXT)
                begin
                    s.selection    = {4'd0, item.jumpers};
                    s.pwm_phase    = 4'd1;
                    s.static_mode  = 1'b1;
                    s.wheel_pos    = 6'd0;
                    if (item.jumpers <= CODE_STATIC_LAST)
                        s.wheel_pos = STATIC_PICK[item.jumpers - 4'd1];
                    s.wheel_length = LONG_WHEEL_LEN;
                    case (item.jumpers)
                        CODE_BLINK_A:
                        begin
                            s.wheel_id     = W_BLINK_A;
                            s.wheel_length = SHORT_WHEEL_LEN;
                        end
                        CODE_BLINK_B:
                        begin
                            s.wheel_id     = W_BLINK_B;
                            s.wheel_length = SHORT_WHEEL_LEN;
                        end
                        CODE_WARM:    s.wheel_id     = W_WARM;
                        CODE_COOL:    s.wheel_id     = W_COOL;
                        CODE_FIRE:    s.wheel_id     = W_FIRE;
                        CODE_RAINBOW: s.wheel_length = RAINBOW_WHEEL_LEN;
                        default:      s.wheel_id     = W_RAINBOW;
                    endcase
                    if (item.jumpers >= CODE_BLINK_A)
                    begin
                        s.static_mode   = 1'b0;
                        s.pattern_index = 3'(item.jumpers - CODE_BLINK_A);
                    end
                    s.levels = color_levels(wheel_entry(s.wheel_id, s.wheel_pos));
                end
                else
                begin
                    // step to the next of the fixed colors, wrapping to red
                    s.static_mode = 1'b1;
                    s.selection   = s.selection + 8'd1;
                    if (s.selection >= 8'(ROM_SIZE))
                        s.selection = 8'd0;
                    s.levels = color_levels(wheel_entry(W_RAINBOW, s.selection[5:0]));
                end
            end
        end

        state_next = s;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (step)
            state_reg <= state_next;
    end

    // result taken after the update
    assign result = '{
        red_on:    state_next.led[0],
        green_on:  state_next.led[1],
        blue_on:   state_next.led[2],
        white_on:  state_next.led[3],
        dim_level: state_next.dim_index
    };

endmodule

>>> design/rgbwseq_checker.sv
// port-level checks of the rgbw color sequencer, bound to the top level
// depends on: rgbwseq_pkg, rgbw_pwm_color_sequencer_macros.svh
`timescale 1ns / 1ps
`include "rgbw_pwm_color_sequencer_macros.svh"

module rgbwseq_port_checker
    import rgbwseq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       red_on,
    input logic       green_on,
    input logic       blue_on,
    input logic       white_on,
    input logic [2:0] dim_level
);

    logic [6:0] out_bits;

    assign out_bits = {red_on, green_on, blue_on, white_on, dim_level};

    // a stalled result stays offered
    `RGBWSEQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")

    // a stalled result keeps its value
    `RGBWSEQ_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_bits), "result changed")

    // with the result register empty, the block takes items
    `RGBWSEQ_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled while empty")

    // dim level stays within the table steps
    `RGBWSEQ_ASSERT(a_dim_range, out_valid |-> dim_level <= DIM_TOP_L, "dim level above top")

    // no result right after reset
    `RGBWSEQ_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind rgbw_pwm_color_sequencer rgbwseq_port_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .red_on    (results.red_on),
    .green_on  (results.green_on),
    .blue_on   (results.blue_on),
    .white_on  (results.white_on),
    .dim_level (results.dim_level)
);
